/* sv/region_decoded_word_ram_macros.svh */
// assertion macros shared by the region decoded word ram checks
`ifndef REGION_DECODED_WORD_RAM_MACROS_SVH
`define REGION_DECODED_WORD_RAM_MACROS_SVH

// same-cycle implication, clocked on aclk, off while in reset
`define RDWR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rdwr same-cycle check failed");

// next-cycle implication, clocked on aclk, off while in reset
`define RDWR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rdwr next-cycle check failed");

`endif

/* sv/rdwr_pkg.sv */
// shared types, constants and byte swap helpers for the region decoded word ram
package rdwr_pkg;

    localparam int NUM_AREAS   = 4;
    localparam int AREA_WORDS  = 1024;
    localparam int ADDR_BITS   = 24;
    localparam int WORD_W      = 16;
    localparam int DATA_W      = 32;
    localparam int SIZE_W      = 11;
    localparam int DESC_W      = 37;
    localparam int CFG_IDX_W   = 2;
    localparam int SIZE_LSB    = 24;
    localparam int ACC_RD_BIT  = 35;
    localparam int ACC_WR_BIT  = 36;

    localparam int AREA_IDX_W  = $clog2(NUM_AREAS);
    localparam int AREA_AW     = $clog2(AREA_WORDS);
    localparam int STORE_AW    = AREA_IDX_W + AREA_AW;
    localparam int BANK_AW     = STORE_AW - 1;
    localparam int BANK_DEPTH  = (NUM_AREAS * AREA_WORDS) / 2;

    localparam logic [1:0] BO_BIG = 2'd0;

    typedef enum logic [2:0] {
        KIND_RD_WORD  = 3'd0,
        KIND_WR_WORD  = 3'd1,
        KIND_RD_DWORD = 3'd2,
        KIND_WR_DWORD = 3'd3,
        KIND_RD_BIT   = 3'd4,
        KIND_WR_BIT   = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_READ,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic clear;
        logic lookup;
        logic read;
        logic commit;
    } rdwr_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } rdwr_stat_t;

    function automatic logic [WORD_W-1:0] swap16(input logic [WORD_W-1:0] x);
        return {x[7:0], x[15:8]};
    endfunction

    function automatic logic [DATA_W-1:0] swap32(input logic [DATA_W-1:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

/* sv/rdwr_ram.sv */
// generic single write, single read port ram with registered read data
module rdwr_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/rdwr_ctrl.sv */
// controller state machine: clear sweep, accept, lookup, read, execute
module rdwr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  rdwr_pkg::rdwr_stat_t  stat,
    output rdwr_pkg::rdwr_cmd_t   cmd
);

    rdwr_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rdwr_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rdwr_pkg::S_CLEAR: begin
                if (stat.clear_last) state_next = rdwr_pkg::S_IDLE;
            end
            rdwr_pkg::S_IDLE: begin
                if (s_tvalid) state_next = rdwr_pkg::S_LOOKUP;
            end
            rdwr_pkg::S_LOOKUP: state_next = rdwr_pkg::S_READ;
            rdwr_pkg::S_READ:   state_next = rdwr_pkg::S_EXEC;
            rdwr_pkg::S_EXEC: begin
                if (stat.out_free) state_next = rdwr_pkg::S_IDLE;
            end
            default: state_next = rdwr_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            rdwr_pkg::S_CLEAR:  cmd.clear    = 1'b1;
            rdwr_pkg::S_IDLE:   cmd.in_ready = 1'b1;
            rdwr_pkg::S_LOOKUP: cmd.lookup   = 1'b1;
            rdwr_pkg::S_READ:   cmd.read     = 1'b1;
            rdwr_pkg::S_EXEC:   cmd.commit   = stat.out_free;
            default:            cmd = '0;
        endcase
    end

endmodule

/* sv/rdwr_dp.sv */
// datapath: descriptors, area lookup, two word banks, data conversion, output register
module rdwr_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rdwr_pkg::rdwr_cmd_t               cmd,
    output rdwr_pkg::rdwr_stat_t              stat,
    input  logic                              s_tvalid,
    input  logic [63:0]                       s_tdata,
    input  logic [2:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rdwr_pkg::DATA_W-1:0]       m_tdata,
    output logic                              m_tuser,
    input  logic                              cfg_wr_en,
    input  logic [rdwr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rdwr_pkg::DESC_W-1:0]       cfg_wr_data
);

    logic [rdwr_pkg::DESC_W-1:0]    desc_reg [rdwr_pkg::NUM_AREAS];

    logic [2:0]                     kind_reg;
    logic [1:0]                     cls_reg;
    logic [rdwr_pkg::ADDR_BITS-1:0] addr_reg;
    logic [3:0]                     bitno_reg;
    logic                           big_reg;
    logic [rdwr_pkg::DATA_W-1:0]    wv_reg;

    logic                           ok_reg;
    logic [rdwr_pkg::STORE_AW-1:0]  idx_reg;

    logic [rdwr_pkg::BANK_AW-1:0]   clr_cnt_reg;

    logic                           out_valid_reg;
    logic [rdwr_pkg::DATA_W-1:0]    out_data_reg;
    logic                           out_ok_reg;

    // descriptor registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < rdwr_pkg::NUM_AREAS; i++) begin
                desc_reg[i] <= '0;
            end
        end else if (cfg_wr_en && (int'(cfg_index) < rdwr_pkg::NUM_AREAS)) begin
            desc_reg[cfg_index] <= cfg_wr_data;
        end
    end

    // input beat capture
    always_ff @(posedge aclk) begin
        if (cmd.in_ready && s_tvalid) begin
            kind_reg  <= s_tuser;
            cls_reg   <= s_tdata[1:0];
            addr_reg  <= s_tdata[25:2];
            bitno_reg <= s_tdata[29:26];
            big_reg   <= (s_tdata[31:30] == rdwr_pkg::BO_BIG);
            wv_reg    <= s_tdata[63:32];
        end
    end

    // area lookup: highest base not above the address, ties to the higher index
    logic                             lk_found;
    logic [rdwr_pkg::AREA_IDX_W-1:0]  lk_sel;
    logic [rdwr_pkg::ADDR_BITS-1:0]   lk_best;
    logic [rdwr_pkg::SIZE_W-1:0]      lk_size;
    logic [rdwr_pkg::ADDR_BITS-1:0]   lk_rel;
    logic [rdwr_pkg::ADDR_BITS:0]     lk_need;
    logic                             lk_dword;
    logic                             lk_ok;

    always_comb begin
        logic                           map_rd;
        logic                           map_wr;
        logic                           en;
        logic [rdwr_pkg::ADDR_BITS-1:0] base;
        logic [rdwr_pkg::SIZE_W-1:0]    size_raw;
        map_rd   = cls_reg[0];
        map_wr   = !cls_reg[0] && cls_reg[1];
        lk_found = 1'b0;
        lk_sel   = '0;
        lk_best  = '0;
        for (int i = 0; i < rdwr_pkg::NUM_AREAS; i++) begin
            base = desc_reg[i][rdwr_pkg::ADDR_BITS-1:0];
            en   = (map_rd && desc_reg[i][rdwr_pkg::ACC_RD_BIT])
                || (map_wr && desc_reg[i][rdwr_pkg::ACC_WR_BIT]);
            if (en && (base <= addr_reg) && (!lk_found || (base >= lk_best))) begin
                lk_found = 1'b1;
                lk_sel   = rdwr_pkg::AREA_IDX_W'(i);
                lk_best  = base;
            end
        end
        size_raw = desc_reg[lk_sel][rdwr_pkg::SIZE_LSB +: rdwr_pkg::SIZE_W];
        lk_size  = (size_raw > rdwr_pkg::SIZE_W'(rdwr_pkg::AREA_WORDS))
                 ? rdwr_pkg::SIZE_W'(rdwr_pkg::AREA_WORDS) : size_raw;
        lk_dword = (kind_reg == rdwr_pkg::KIND_RD_DWORD)
                || (kind_reg == rdwr_pkg::KIND_WR_DWORD);
        lk_rel   = addr_reg - lk_best;
        lk_need  = {1'b0, lk_rel} + (lk_dword ? (rdwr_pkg::ADDR_BITS+1)'(2)
                                              : (rdwr_pkg::ADDR_BITS+1)'(1));
        lk_ok    = lk_found && (kind_reg <= rdwr_pkg::KIND_WR_BIT)
                && (lk_need <= (rdwr_pkg::ADDR_BITS+1)'(lk_size));
    end

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            ok_reg  <= lk_ok;
            idx_reg <= {lk_sel, lk_rel[rdwr_pkg::AREA_AW-1:0]};
        end
    end

    // even and odd word banks; a dword always hits both
    logic [rdwr_pkg::BANK_AW-1:0] ev_addr, od_addr;
    logic [rdwr_pkg::BANK_AW-1:0] ev_waddr, od_waddr;
    logic [rdwr_pkg::WORD_W-1:0]  ev_rdata, od_rdata;
    logic [rdwr_pkg::WORD_W-1:0]  ev_wdata, od_wdata;
    logic                         ev_we, od_we;

    assign od_addr = idx_reg[rdwr_pkg::STORE_AW-1:1];
    assign ev_addr = idx_reg[rdwr_pkg::STORE_AW-1:1]
                   + rdwr_pkg::BANK_AW'(idx_reg[0]);

    // execute: data conversion and write data
    logic [rdwr_pkg::WORD_W-1:0]  lo_word, hi_word;
    logic [rdwr_pkg::DATA_W-1:0]  ex_rd;
    logic [rdwr_pkg::WORD_W-1:0]  wr_lo, wr_hi;
    logic                         we_lo, we_hi;

    always_comb begin
        logic [rdwr_pkg::DATA_W-1:0] v;
        logic [rdwr_pkg::WORD_W-1:0] w;
        lo_word = idx_reg[0] ? od_rdata : ev_rdata;
        hi_word = idx_reg[0] ? ev_rdata : od_rdata;
        w       = big_reg ? rdwr_pkg::swap16(lo_word) : lo_word;
        v       = '0;
        ex_rd   = '0;
        wr_lo   = '0;
        wr_hi   = '0;
        we_lo   = 1'b0;
        we_hi   = 1'b0;
        case (rdwr_pkg::kind_t'(kind_reg))
            rdwr_pkg::KIND_RD_WORD: begin
                ex_rd = rdwr_pkg::DATA_W'(w);
            end
            rdwr_pkg::KIND_WR_WORD: begin
                wr_lo = big_reg ? rdwr_pkg::swap16(wv_reg[15:0]) : wv_reg[15:0];
                we_lo = 1'b1;
            end
            rdwr_pkg::KIND_RD_DWORD: begin
                v     = {hi_word, lo_word};
                ex_rd = big_reg ? rdwr_pkg::swap32(v) : v;
            end
            rdwr_pkg::KIND_WR_DWORD: begin
                v     = big_reg ? rdwr_pkg::swap32(wv_reg) : wv_reg;
                wr_lo = v[15:0];
                wr_hi = v[31:16];
                we_lo = 1'b1;
                we_hi = 1'b1;
            end
            rdwr_pkg::KIND_RD_BIT: begin
                ex_rd = rdwr_pkg::DATA_W'(w[bitno_reg]);
            end
            rdwr_pkg::KIND_WR_BIT: begin
                w     = (w & ~(rdwr_pkg::WORD_W'(1) << bitno_reg))
                      | (rdwr_pkg::WORD_W'(wv_reg[0]) << bitno_reg);
                wr_lo = big_reg ? rdwr_pkg::swap16(w) : w;
                we_lo = 1'b1;
            end
            default: begin
                ex_rd = '0;
            end
        endcase
    end

    // bank write side: clear sweep or commit
    always_comb begin
        if (cmd.clear) begin
            ev_we    = 1'b1;
            od_we    = 1'b1;
            ev_waddr = clr_cnt_reg;
            od_waddr = clr_cnt_reg;
            ev_wdata = '0;
            od_wdata = '0;
        end else begin
            ev_we    = cmd.commit && ok_reg && (idx_reg[0] ? we_hi : we_lo);
            od_we    = cmd.commit && ok_reg && (idx_reg[0] ? we_lo : we_hi);
            ev_waddr = ev_addr;
            od_waddr = od_addr;
            ev_wdata = idx_reg[0] ? wr_hi : wr_lo;
            od_wdata = idx_reg[0] ? wr_lo : wr_hi;
        end
    end

    rdwr_ram #(
        .DEPTH(rdwr_pkg::BANK_DEPTH),
        .WIDTH(rdwr_pkg::WORD_W)
    ) u_ev_bank (
        .aclk  (aclk),
        .we    (ev_we),
        .waddr (ev_waddr),
        .wdata (ev_wdata),
        .re    (cmd.read),
        .raddr (ev_addr),
        .rdata (ev_rdata)
    );

    rdwr_ram #(
        .DEPTH(rdwr_pkg::BANK_DEPTH),
        .WIDTH(rdwr_pkg::WORD_W)
    ) u_od_bank (
        .aclk  (aclk),
        .we    (od_we),
        .waddr (od_waddr),
        .wdata (od_wdata),
        .re    (cmd.read),
        .raddr (od_addr),
        .rdata (od_rdata)
    );

    // clear sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear) begin
            clr_cnt_reg <= clr_cnt_reg + rdwr_pkg::BANK_AW'(1);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_data_reg <= ok_reg ? ex_rd : '0;
            out_ok_reg   <= ok_reg;
        end
    end

    assign stat.clear_last = (clr_cnt_reg == rdwr_pkg::BANK_AW'(rdwr_pkg::BANK_DEPTH - 1));
    assign stat.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ok_reg;

endmodule

/* sv/region_decoded_word_ram.sv */
// region decoded word ram top level
// steps per beat: accept, area lookup, bank read, execute; a new beat is taken only
// after the execute step has loaded the last result into the output register, and
// the execute step waits while the output register holds an untaken result
// reset clears the descriptors, then sweeps all 2048 entries of both banks to zero
// with s_tready low; configuration writes are taken during the sweep
`include "region_decoded_word_ram_macros.svh"

module region_decoded_word_ram (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // access_class[1:0], word_address[25:2], bit_number[29:26],
    // byte_order[31:30], write_value[63:32]
    input  logic [63:0]                    s_tdata,
    // kind[2:0]
    input  logic [2:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_value[31:0]
    output logic [rdwr_pkg::DATA_W-1:0]    m_tdata,
    // ok[0]
    output logic                           m_tuser,
    input  logic                           cfg_wr_en,
    input  logic [rdwr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rdwr_pkg::DESC_W-1:0]    cfg_wr_data
);

    rdwr_pkg::rdwr_cmd_t  cmd;
    rdwr_pkg::rdwr_stat_t stat;

    rdwr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    rdwr_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_tvalid    (s_tvalid),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    assign s_tready = cmd.in_ready;

    // no beat is taken while the banks are being swept
    `RDWR_ASSERT_NOW(a_no_accept_in_clear, cmd.clear, !s_tready)
    // a result is only loaded when the output register is free
    `RDWR_ASSERT_NOW(a_commit_slot_free, cmd.commit, !m_tvalid || m_tready)
    // one beat in flight at a time
    `RDWR_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
    // a committed result shows up on the next cycle
    `RDWR_ASSERT_NEXT(a_commit_shows, cmd.commit, m_tvalid)

endmodule

/* tb/sv/region_decoded_word_ram_test.sv */
// self-checking testbench for the region decoded word ram: directed and random accesses
module region_decoded_word_ram_test;
    timeunit 1ns;
    timeprecision 1ps;

    // codes not covered by the package enums
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;
    localparam logic [1:0] BO_LITTLE   = 2'd1;
    localparam logic [1:0] BO_NATIVE   = 2'd2;
    localparam logic [1:0] BO_SPARE    = 2'd3;
    localparam logic [1:0] CLS_NONE    = 2'd0;
    localparam logic [1:0] CLS_READ    = 2'd1;
    localparam logic [1:0] CLS_WRITE   = 2'd2;
    localparam logic [1:0] CLS_BOTH    = 2'd3;
    localparam logic [1:0] ACC_NONE    = 2'd0;
    localparam logic [1:0] ACC_R       = 2'd1;
    localparam logic [1:0] ACC_W       = 2'd2;
    localparam logic [1:0] ACC_RW      = 2'd3;

    localparam int WATCHDOG_LIMIT = 8000;
    localparam int LONG_HOLD      = 80;
    localparam int TAIL_CYCLES    = 8;

    typedef struct packed {
        logic [rdwr_pkg::DATA_W-1:0] rd;
        logic                        ok;
    } ram_result_t;

    class word_ram_scoreboard;
        logic [rdwr_pkg::DESC_W-1:0] desc [rdwr_pkg::NUM_AREAS];
        logic [rdwr_pkg::WORD_W-1:0] store [rdwr_pkg::NUM_AREAS*rdwr_pkg::AREA_WORDS];
        ram_result_t                 expected_results [$];
        int                          errors;

        function new();
            foreach (desc[i]) desc[i] = '0;
            foreach (store[i]) store[i] = '0;
            errors = 0;
        endfunction

        static function logic [rdwr_pkg::WORD_W-1:0] flip16(logic [rdwr_pkg::WORD_W-1:0] x);
            return {x[7:0], x[15:8]};
        endfunction

        static function logic [rdwr_pkg::DATA_W-1:0] flip32(logic [rdwr_pkg::DATA_W-1:0] x);
            return {x[7:0], x[15:8], x[23:16], x[31:24]};
        endfunction

        function void set_area(int i, logic [rdwr_pkg::DESC_W-1:0] d);
            desc[i] = d;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // works out the result of one access and applies its write
        function void predict_access(logic [2:0] kind, logic [1:0] cls, logic [23:0] addr,
                                     logic [3:0] bitno, logic [1:0] order,
                                     logic [rdwr_pkg::DATA_W-1:0] wv);
            ram_result_t                 r;
            logic [1:0]                  mapbit;
            int                          found;
            int                          best;
            int                          base;
            int                          size;
            int                          rel;
            int                          words;
            int                          idx;
            bit                          big;
            logic [rdwr_pkg::WORD_W-1:0] raw;
            logic [rdwr_pkg::WORD_W-1:0] w;
            logic [rdwr_pkg::DATA_W-1:0] v;
            r = '0;
            found = -1;
            best = 0;
            idx = -1;
            big = (order == rdwr_pkg::BO_BIG);
            words = (kind == rdwr_pkg::KIND_RD_DWORD || kind == rdwr_pkg::KIND_WR_DWORD)
                  ? 2 : 1;
            // read map wins when both class bits are set
            mapbit = cls[0] ? ACC_R : (cls[1] ? ACC_W : ACC_NONE);
            if (mapbit != ACC_NONE && kind <= rdwr_pkg::KIND_WR_BIT) begin
                for (int i = 0; i < rdwr_pkg::NUM_AREAS; i++) begin
                    base = int'(desc[i][rdwr_pkg::ADDR_BITS-1:0]);
                    if ((desc[i][rdwr_pkg::ACC_WR_BIT:rdwr_pkg::ACC_RD_BIT] & mapbit) != 0
                        && base <= int'(addr) && (found < 0 || base >= best)) begin
                        found = i;
                        best = base;
                    end
                end
            end
            if (found >= 0) begin
                size = int'(desc[found][rdwr_pkg::SIZE_LSB+rdwr_pkg::SIZE_W-1:rdwr_pkg::SIZE_LSB]);
                if (size > rdwr_pkg::AREA_WORDS) size = rdwr_pkg::AREA_WORDS;
                rel = int'(addr) - best;
                if (rel + words <= size) idx = found * rdwr_pkg::AREA_WORDS + rel;
            end
            if (idx >= 0) begin
                r.ok = 1'b1;
                raw = store[idx];
                case (kind)
                    rdwr_pkg::KIND_RD_WORD: r.rd = {16'h0, big ? flip16(raw) : raw};
                    rdwr_pkg::KIND_WR_WORD: store[idx] = big ? flip16(wv[15:0]) : wv[15:0];
                    rdwr_pkg::KIND_RD_DWORD: begin
                        v = {store[idx+1], raw};
                        r.rd = big ? flip32(v) : v;
                    end
                    rdwr_pkg::KIND_WR_DWORD: begin
                        v = big ? flip32(wv) : wv;
                        store[idx] = v[15:0];
                        store[idx+1] = v[31:16];
                    end
                    rdwr_pkg::KIND_RD_BIT: begin
                        w = big ? flip16(raw) : raw;
                        r.rd = {31'h0, w[bitno]};
                    end
                    default: begin
                        w = big ? flip16(raw) : raw;
                        w[bitno] = wv[0];
                        store[idx] = big ? flip16(w) : w;
                    end
                endcase
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [rdwr_pkg::DATA_W-1:0] rd, logic ok);
            ram_result_t want;
            if (expected_results.size() == 0) begin
                errors++;
                $error("unexpected result beat: read_value %h ok %b", rd, ok);
                return;
            end
            want = expected_results.pop_front();
            if (rd !== want.rd) begin
                errors++;
                $error("read_value: expected %h, actual %h", want.rd, rd);
            end
            if (ok !== want.ok) begin
                errors++;
                $error("ok: expected %b, actual %b", want.ok, ok);
            end
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn     = 1'b0;
    logic                           s_tvalid    = 1'b0;
    logic                           s_tready;
    logic [63:0]                    s_tdata     = '0;
    logic [2:0]                     s_tuser     = '0;
    logic                           m_tvalid;
    logic                           m_tready    = 1'b0;
    logic [rdwr_pkg::DATA_W-1:0]    m_tdata;
    logic                           m_tuser;
    logic                           cfg_wr_en   = 1'b0;
    logic [rdwr_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
    logic [rdwr_pkg::DESC_W-1:0]    cfg_wr_data = '0;

    word_ram_scoreboard          ram_model = new();
    logic [rdwr_pkg::DESC_W-1:0] area_cfg [rdwr_pkg::NUM_AREAS];
    bit                          quiet      = 1'b0;
    int                          hold_req   = 0;
    int                          hold_taken = 0;
    int                          hold_left  = 0;
    int                          stall_cycles = 0;

    region_decoded_word_ram u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: random short stalls, plus a long hold when requested
    always @(negedge aclk) begin
        if (hold_taken != hold_req) begin
            hold_taken <= hold_req;
            hold_left <= LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            hold_left <= $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result check and watchdog on cycles with no beat moving
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) ram_model.check_result(m_tdata, m_tuser);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [rdwr_pkg::DESC_W-1:0] make_desc(int base, int size,
                                                              logic [1:0] acc);
        return {acc, size[rdwr_pkg::SIZE_W-1:0], base[rdwr_pkg::ADDR_BITS-1:0]};
    endfunction

    task automatic send_access(logic [2:0] kind, logic [1:0] cls, logic [23:0] addr,
                               logic [3:0] bitno, logic [1:0] order,
                               logic [rdwr_pkg::DATA_W-1:0] wv);
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {wv, order, bitno, addr, cls};
        s_tuser <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ram_model.predict_access(kind, cls, addr, bitno, order, wv);
    endtask

    // stop offering beats and let every outstanding result come back
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (ram_model.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic program_areas();
        for (int i = 0; i < rdwr_pkg::NUM_AREAS; i++) begin
            @(negedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= rdwr_pkg::CFG_IDX_W'(i);
            cfg_wr_data <= area_cfg[i];
            @(posedge aclk);
            ram_model.set_area(i, area_cfg[i]);
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly accesses aimed at an area: its start, its end, or anywhere inside
    task automatic random_access();
        logic [2:0]  kind;
        logic [1:0]  cls;
        logic [23:0] addr;
        int          a;
        int          eff;
        int          off;
        a = $urandom_range(0, rdwr_pkg::NUM_AREAS - 1);
        eff = int'(ram_model.desc[a][rdwr_pkg::SIZE_LSB+rdwr_pkg::SIZE_W-1:rdwr_pkg::SIZE_LSB]);
        if (eff > rdwr_pkg::AREA_WORDS) eff = rdwr_pkg::AREA_WORDS;
        if ($urandom_range(0, 9) == 0) begin
            addr = 24'($urandom);
        end else begin
            case ($urandom_range(0, 2))
                0: off = $urandom_range(0, 7);
                1: off = eff + $urandom_range(0, 4) - 3;
                default: off = $urandom_range(0, eff + 1);
            endcase
            if (off < 0) off = 0;
            addr = ram_model.desc[a][rdwr_pkg::ADDR_BITS-1:0] + 24'(off);
        end
        if ($urandom_range(0, 15) == 0) kind = 3'($urandom_range(KIND_SPARE6, KIND_SPARE7));
        else kind = 3'($urandom_range(rdwr_pkg::KIND_RD_WORD, rdwr_pkg::KIND_WR_BIT));
        if ($urandom_range(0, 11) == 0) cls = 2'($urandom_range(CLS_NONE, CLS_BOTH));
        else if (ram_model.desc[a][rdwr_pkg::ACC_RD_BIT])
            cls = $urandom_range(0, 1) ? CLS_READ : CLS_BOTH;
        else cls = CLS_WRITE;
        send_access(kind, cls, addr, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                    $urandom);
    endtask

    task automatic random_run(int n, int hold_at);
        for (int k = 0; k < n; k++) begin
            if (k == hold_at) hold_req++;
            random_access();
        end
    endtask

    task automatic random_areas();
        for (int i = 0; i < rdwr_pkg::NUM_AREAS; i++) begin
            if ($urandom_range(0, 2) == 0)
                area_cfg[i] = rdwr_pkg::DESC_W'({$urandom, $urandom});
            else
                area_cfg[i] = make_desc(int'($urandom_range(0, 4095)),
                                        int'($urandom_range(1, 1100)),
                                        2'($urandom_range(ACC_R, ACC_RW)));
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // descriptors still at reset: nothing can be found
        send_access(rdwr_pkg::KIND_RD_WORD, CLS_READ, 24'h000000, 4'd0, rdwr_pkg::BO_BIG,
                    32'h0);
        send_access(rdwr_pkg::KIND_WR_DWORD, CLS_WRITE, 24'hFFFFFF, 4'd15, BO_LITTLE,
                    32'hFFFFFFFF);
        send_access(rdwr_pkg::KIND_RD_BIT, CLS_BOTH, 24'h000010, 4'd7, BO_NATIVE, 32'h0);
        drain();

        // area2 ties area1 in the read map, area2 and area3 exceed the storage
        area_cfg[0] = make_desc('h000010, 1024, ACC_RW);
        area_cfg[1] = make_desc('h000400, 16, ACC_R);
        area_cfg[2] = make_desc('h000400, 2047, ACC_RW);
        area_cfg[3] = make_desc('hFFFFF0, 2047, ACC_RW);
        program_areas();
        send_access(rdwr_pkg::KIND_RD_WORD, CLS_READ, 24'h000000, 4'd0, rdwr_pkg::BO_BIG,
                    32'h0);
        send_access(rdwr_pkg::KIND_RD_WORD, CLS_READ, 24'h000010, 4'd0, rdwr_pkg::BO_BIG,
                    32'h0);
        send_access(rdwr_pkg::KIND_WR_WORD, CLS_WRITE, 24'h000010, 4'd0, rdwr_pkg::BO_BIG,
                    32'hFFFFA1B2);
        send_access(rdwr_pkg::KIND_RD_WORD, CLS_READ, 24'h000010, 4'd0, BO_LITTLE, 32'h0);
        send_access(rdwr_pkg::KIND_RD_WORD, CLS_READ, 24'h000010, 4'd0, rdwr_pkg::BO_BIG,
                    32'h0);
        send_access(rdwr_pkg::KIND_WR_DWORD, CLS_WRITE, 24'h0007FE, 4'd0, BO_LITTLE,
                    32'hFFFFFFFF);
        send_access(rdwr_pkg::KIND_WR_DWORD, CLS_WRITE, 24'h0007FF, 4'd0, BO_LITTLE,
                    32'h12345678);
        send_access(rdwr_pkg::KIND_WR_WORD, CLS_WRITE, 24'h000800, 4'd0, BO_LITTLE,
                    32'h0000BEEF);
        send_access(rdwr_pkg::KIND_RD_DWORD, CLS_BOTH, 24'h0007FE, 4'd0, rdwr_pkg::BO_BIG,
                    32'h0);
        send_access(rdwr_pkg::KIND_WR_BIT, CLS_WRITE, 24'h0007FF, 4'd15, rdwr_pkg::BO_BIG,
                    32'h0);
        send_access(rdwr_pkg::KIND_RD_WORD, CLS_READ, 24'h0007FF, 4'd0, BO_LITTLE, 32'h0);
        send_access(rdwr_pkg::KIND_WR_BIT, CLS_WRITE, 24'h000020, 4'd0, BO_LITTLE,
                    32'hFFFFFFFF);
        send_access(rdwr_pkg::KIND_RD_BIT, CLS_READ, 24'h000020, 4'd0, BO_LITTLE, 32'h0);
        send_access(rdwr_pkg::KIND_RD_BIT, CLS_READ, 24'h000020, 4'd15, BO_LITTLE, 32'h0);
        send_access(KIND_SPARE6, CLS_READ, 24'h000010, 4'd0, rdwr_pkg::BO_BIG, 32'h0);
        send_access(KIND_SPARE7, CLS_WRITE, 24'h000010, 4'd0, rdwr_pkg::BO_BIG, 32'hFFFFFFFF);
        send_access(rdwr_pkg::KIND_RD_WORD, CLS_NONE, 24'h000010, 4'd0, rdwr_pkg::BO_BIG,
                    32'h0);
        send_access(rdwr_pkg::KIND_WR_WORD, CLS_WRITE, 24'h000011, 4'd0, BO_SPARE,
                    32'h00001234);
        send_access(rdwr_pkg::KIND_RD_WORD, CLS_READ, 24'h000011, 4'd0, rdwr_pkg::BO_BIG,
                    32'h0);
        send_access(rdwr_pkg::KIND_WR_DWORD, CLS_WRITE, 24'hFFFFFE, 4'd0, rdwr_pkg::BO_BIG,
                    32'h89ABCDEF);
        send_access(rdwr_pkg::KIND_RD_DWORD, CLS_READ, 24'hFFFFFE, 4'd0, BO_LITTLE, 32'h0);
        send_access(rdwr_pkg::KIND_RD_WORD, CLS_BOTH, 24'hFFFFFF, 4'd0, BO_NATIVE, 32'h0);
        send_access(rdwr_pkg::KIND_RD_WORD, CLS_READ, 24'h00040F, 4'd0, rdwr_pkg::BO_BIG,
                    32'h0);
        random_run(100, 30);
        drain();

        // equal bases in one map, a zero-size area, an area at the top address
        area_cfg[0] = make_desc('h000100, 64, ACC_RW);
        area_cfg[1] = make_desc('h000100, 32, ACC_RW);
        area_cfg[2] = make_desc('h000200, 0, ACC_RW);
        area_cfg[3] = make_desc('hFFFFFF, 2047, ACC_W);
        program_areas();
        send_access(rdwr_pkg::KIND_RD_WORD, CLS_READ, 24'h000120, 4'd0, rdwr_pkg::BO_BIG,
                    32'h0);
        send_access(rdwr_pkg::KIND_RD_WORD, CLS_READ, 24'h00011F, 4'd0, rdwr_pkg::BO_BIG,
                    32'h0);
        send_access(rdwr_pkg::KIND_WR_WORD, CLS_WRITE, 24'h000200, 4'd0, rdwr_pkg::BO_BIG,
                    32'h0000FFFF);
        send_access(rdwr_pkg::KIND_WR_WORD, CLS_WRITE, 24'hFFFFFF, 4'd0, rdwr_pkg::BO_BIG,
                    32'h0000FFFF);
        send_access(rdwr_pkg::KIND_RD_WORD, CLS_READ, 24'hFFFFFF, 4'd0, rdwr_pkg::BO_BIG,
                    32'h0);
        random_run(100, -1);
        drain();

        // every descriptor bit set
        foreach (area_cfg[i]) area_cfg[i] = '1;
        program_areas();
        random_run(40, -1);
        drain();

        for (int s = 0; s < 3; s++) begin
            random_areas();
            program_areas();
            random_run(80, (s == 1) ? 20 : -1);
            drain();
        end

        // last stretch without any idling
        random_areas();
        program_areas();
        quiet = 1'b1;
        random_run(60, -1);
        drain();

        if (ram_model.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
